// File: hdl/sqp_pkg.sv
// Shared types, constants and the divider step for signal_quality_percent.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sqp_pkg;

    // Field widths
    localparam int C_BYTE_W = 8;
    localparam int C_PCT_W  = 7;
    localparam int C_IDX_W  = 3;

    // Divider geometry: quotient is below 128 wherever it is used, dividend below 2^15
    localparam int C_QUO_W = 7;
    localparam int C_NUM_W = 15;

    // Arithmetic constants
    localparam int C_FULL_PERCENT    = 100;
    localparam int C_DBM_SPAN        = 70;
    localparam int C_DBM_OFFSET      = 'h100;
    localparam int C_NOISE_FLOOR_DBM = -90;
    localparam int C_SIGNAL_MAX_DBM  = -20;

    // dBm clamp bounds expressed as raw report bytes (dBm plus offset)
    localparam logic [C_BYTE_W-1:0] C_LVL_LO_BYTE =
        C_BYTE_W'(C_DBM_OFFSET + C_NOISE_FLOOR_DBM);
    localparam logic [C_BYTE_W-1:0] C_LVL_HI_BYTE =
        C_BYTE_W'(C_DBM_OFFSET + C_SIGNAL_MAX_DBM);

    // Configuration register indexes
    typedef enum logic [C_IDX_W-1:0] {
        REG_MAX_QUALITY         = 3'd0,
        REG_LEVEL_SCALE         = 3'd1,
        REG_MAX_NOISE           = 3'd2,
        REG_MAX_QUALITY_INVALID = 3'd3,
        REG_LEVEL_SCALE_INVALID = 3'd4,
        REG_MAX_NOISE_INVALID   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [C_BYTE_W-1:0] max_quality;
        logic [C_BYTE_W-1:0] level_scale;
        logic [C_BYTE_W-1:0] max_noise;
        logic                max_quality_invalid;
        logic                level_scale_invalid;
        logic                max_noise_invalid;
    } t_cfg;

    // One divider lane: partial remainder, divisor, quotient bits so far
    typedef struct packed {
        logic [C_NUM_W-1:0]  rem;
        logic [C_BYTE_W-1:0] den;
        logic [C_QUO_W-1:0]  quo;
    } t_div_lane;

    // Decisions made up front that ride along with the dividers
    typedef struct packed {
        logic link_ok;   // link ratio present
        logic link_sat;  // link ratio is at least full scale
        logic lvl_ok;    // level figure present and not negative
    } t_ctl;

    // One restoring division step for quotient bit k
    function automatic t_div_lane div_step(t_div_lane x, int k);
        logic [C_NUM_W-1:0] sh;
        t_div_lane          y;
        sh = C_NUM_W'(x.den) << k;
        y  = x;
        if (x.rem >= sh) begin
            y.rem    = x.rem - sh;
            y.quo[k] = 1'b1;
        end
        return y;
    endfunction

endpackage

// File: hdl/sqp_if.sv
// Channel interfaces for signal_quality_percent: report in, percent out, config writes.
// Depends on sqp_pkg for field widths.
`timescale 1ns / 1ps

interface sqp_in_if import sqp_pkg::*;;
    logic                valid;
    logic                ready;
    logic [C_BYTE_W-1:0] link_quality;
    logic [C_BYTE_W-1:0] signal_level;
    logic [C_BYTE_W-1:0] noise_level;
    logic                quality_invalid;
    logic                level_invalid;
    logic                noise_invalid;

    modport source (output valid, link_quality, signal_level, noise_level,
                    quality_invalid, level_invalid, noise_invalid, input ready);
    modport sink   (input valid, link_quality, signal_level, noise_level,
                    quality_invalid, level_invalid, noise_invalid, output ready);
endinterface

interface sqp_out_if import sqp_pkg::*;;
    logic               valid;
    logic               ready;
    logic [C_PCT_W-1:0] quality_percent;

    modport source (output valid, quality_percent, input ready);
    modport sink   (input valid, quality_percent, output ready);
endinterface

interface sqp_cfg_if import sqp_pkg::*;;
    logic                valid;
    logic                ready;
    logic [C_IDX_W-1:0]  index;
    logic [C_BYTE_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/sqp_prep.sv
// First pipeline stage: picks the mode, clamps level and noise, forms dividends.
// Depends on sqp_pkg.
`timescale 1ns / 1ps

module sqp_prep import sqp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_cfg                i_cfg,
    input  logic [C_BYTE_W-1:0] i_link_quality,
    input  logic [C_BYTE_W-1:0] i_signal_level,
    input  logic [C_BYTE_W-1:0] i_noise_level,
    input  logic                i_quality_invalid,
    input  logic                i_level_invalid,
    input  logic                i_noise_invalid,
    output logic                o_valid,
    output t_ctl                o_ctl,
    output t_div_lane           o_link,
    output t_div_lane           o_lvl
);

    logic                r_valid;
    t_ctl                r_ctl,  n_ctl;
    t_div_lane           r_link, n_link;
    t_div_lane           r_lvl,  n_lvl;

    logic                own_noise_ok, max_noise_ok, dbm_mode, rssi_mode;
    logic [C_BYTE_W-1:0] noise_byte, noise_clamp, sig_clamp, rssi_clamp;
    logic [C_QUO_W-1:0]  span_a, span_b;
    logic [C_NUM_W-1:0]  num_pos, num_neg;

    // Decode the report against the card limits
    always_comb begin
        own_noise_ok = (i_noise_level != '0) && !i_noise_invalid;
        max_noise_ok = (i_cfg.max_noise != '0) && !i_cfg.max_noise_invalid;
        dbm_mode  = (i_cfg.level_scale == '0) && !i_cfg.level_scale_invalid &&
                    !i_level_invalid && (own_noise_ok || max_noise_ok);
        rssi_mode = (i_cfg.level_scale != '0) && !i_cfg.level_scale_invalid &&
                    !i_level_invalid;

        // Clamp signal and noise to the usable dBm window
        noise_byte = own_noise_ok ? i_noise_level : i_cfg.max_noise;
        if (noise_byte < C_LVL_LO_BYTE) begin
            noise_clamp = C_LVL_LO_BYTE;
        end else if (noise_byte > C_LVL_HI_BYTE) begin
            noise_clamp = C_LVL_HI_BYTE;
        end else begin
            noise_clamp = noise_byte;
        end
        if (i_signal_level < C_LVL_LO_BYTE) begin
            sig_clamp = C_LVL_LO_BYTE;
        end else if (i_signal_level > C_LVL_HI_BYTE) begin
            sig_clamp = C_LVL_HI_BYTE;
        end else begin
            sig_clamp = i_signal_level;
        end
        span_a  = C_QUO_W'(C_LVL_HI_BYTE - sig_clamp);
        span_b  = C_QUO_W'(C_LVL_HI_BYTE - noise_clamp);
        num_pos = C_NUM_W'(span_b) * C_NUM_W'(C_FULL_PERCENT);
        num_neg = C_NUM_W'(span_a) * C_NUM_W'(C_DBM_SPAN);

        rssi_clamp = (i_signal_level > i_cfg.level_scale) ? i_cfg.level_scale
                                                          : i_signal_level;

        // Link quality ratio
        n_ctl.link_ok  = (i_cfg.max_quality != '0) && !i_cfg.max_quality_invalid &&
                         !i_quality_invalid;
        n_ctl.link_sat = (i_link_quality >= i_cfg.max_quality);
        n_link.rem     = C_NUM_W'(i_link_quality) * C_NUM_W'(C_FULL_PERCENT);
        n_link.den     = i_cfg.max_quality;
        n_link.quo     = '0;

        // Level figure; a small negative dBm ratio truncates to zero
        n_lvl.quo = '0;
        if (dbm_mode) begin
            // Divide zero by one when the span is empty so the figure reads 0
            n_lvl.den = (span_b == '0) ? C_BYTE_W'(1) : C_BYTE_W'(span_b);
            if (span_b == '0) begin
                n_ctl.lvl_ok = 1'b1;
                n_lvl.rem    = '0;
            end else if (num_pos >= num_neg) begin
                n_ctl.lvl_ok = 1'b1;
                n_lvl.rem    = num_pos - num_neg;
            end else begin
                n_ctl.lvl_ok = (num_neg < num_pos + C_NUM_W'(span_b));
                n_lvl.rem    = '0;
            end
        end else begin
            n_ctl.lvl_ok = rssi_mode;
            n_lvl.den    = i_cfg.level_scale;
            n_lvl.rem    = C_NUM_W'(rssi_clamp) * C_NUM_W'(C_FULL_PERCENT);
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl  <= n_ctl;
            r_link <= n_link;
            r_lvl  <= n_lvl;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_link  = r_link;
    assign o_lvl   = r_lvl;

endmodule

// File: hdl/sqp_div.sv
// Restoring divider pipeline, one quotient bit per stage, two lanes side by side.
// Depends on sqp_pkg for lane types and the step function.
`timescale 1ns / 1ps

module sqp_div import sqp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_ctl      i_ctl,
    input  t_div_lane i_link,
    input  t_div_lane i_lvl,
    output logic      o_valid,
    output t_ctl      o_ctl,
    output t_div_lane o_link,
    output t_div_lane o_lvl
);

    logic      r_valid [C_QUO_W];
    t_ctl      r_ctl   [C_QUO_W];
    t_div_lane r_link  [C_QUO_W];
    t_div_lane r_lvl   [C_QUO_W];

    for (genvar s = 0; s < C_QUO_W; s++) begin : g_stage
        logic      valid_in;
        t_ctl      ctl_in;
        t_div_lane link_in, lvl_in;

        // Take from the previous stage, or from the port at the head
        if (s == 0) begin : g_head
            assign valid_in = i_valid;
            assign ctl_in   = i_ctl;
            assign link_in  = i_link;
            assign lvl_in   = i_lvl;
        end else begin : g_body
            assign valid_in = r_valid[s-1];
            assign ctl_in   = r_ctl[s-1];
            assign link_in  = r_link[s-1];
            assign lvl_in   = r_lvl[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= valid_in;
            end
        end

        // Resolve quotient bit C_QUO_W-1-s in both lanes
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[s]  <= ctl_in;
                r_link[s] <= div_step(link_in, C_QUO_W - 1 - s);
                r_lvl[s]  <= div_step(lvl_in, C_QUO_W - 1 - s);
            end
        end
    end

    assign o_valid = r_valid[C_QUO_W-1];
    assign o_ctl   = r_ctl[C_QUO_W-1];
    assign o_link  = r_link[C_QUO_W-1];
    assign o_lvl   = r_lvl[C_QUO_W-1];

endmodule

// File: hdl/signal_quality_percent.sv
// Pipeline from input transfer to result: 1 prep stage, 7 divider stages,
// 1 output register. Throughput: one report per cycle; the whole
// pipeline advances together, held only while the output register is full
// and not taken. Reset: synchronous active low, clears all valid bits, sets
// the maxima to 0 and the three invalid flags to 1. Config writes never stall.
`timescale 1ns / 1ps

module signal_quality_percent import sqp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sqp_cfg_if.sink   i_cfg,
    sqp_in_if.sink    i_in,
    sqp_out_if.source o_out
);

    t_cfg               r_cfg;
    logic               r_out_valid;
    logic [C_PCT_W-1:0] r_out_pct, n_out_pct;

    logic               en;
    logic               pre_valid, div_valid;
    t_ctl               pre_ctl, div_ctl;
    t_div_lane          pre_link, pre_lvl, div_link, div_lvl;
    logic               link_good;
    logic [C_PCT_W-1:0] link_pct;

    // Configuration registers; indexes past the list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_quality         <= '0;
            r_cfg.level_scale         <= '0;
            r_cfg.max_noise           <= '0;
            r_cfg.max_quality_invalid <= 1'b1;
            r_cfg.level_scale_invalid <= 1'b1;
            r_cfg.max_noise_invalid   <= 1'b1;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                REG_MAX_QUALITY:         r_cfg.max_quality         <= i_cfg.data;
                REG_LEVEL_SCALE:         r_cfg.level_scale         <= i_cfg.data;
                REG_MAX_NOISE:           r_cfg.max_noise           <= i_cfg.data;
                REG_MAX_QUALITY_INVALID: r_cfg.max_quality_invalid <= i_cfg.data[0];
                REG_LEVEL_SCALE_INVALID: r_cfg.level_scale_invalid <= i_cfg.data[0];
                REG_MAX_NOISE_INVALID:   r_cfg.max_noise_invalid   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Advance whenever the output register is empty or being drained
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    sqp_prep u_prep (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (i_in.valid),
        .i_cfg             (r_cfg),
        .i_link_quality    (i_in.link_quality),
        .i_signal_level    (i_in.signal_level),
        .i_noise_level     (i_in.noise_level),
        .i_quality_invalid (i_in.quality_invalid),
        .i_level_invalid   (i_in.level_invalid),
        .i_noise_invalid   (i_in.noise_invalid),
        .o_valid           (pre_valid),
        .o_ctl             (pre_ctl),
        .o_link            (pre_link),
        .o_lvl             (pre_lvl)
    );

    sqp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pre_valid),
        .i_ctl   (pre_ctl),
        .i_link  (pre_link),
        .i_lvl   (pre_lvl),
        .o_valid (div_valid),
        .o_ctl   (div_ctl),
        .o_link  (div_link),
        .o_lvl   (div_lvl)
    );

    // Prefer a nonzero link ratio, else fall back to the level figure
    always_comb begin
        link_pct  = div_ctl.link_sat ? C_PCT_W'(C_FULL_PERCENT) : div_link.quo;
        link_good = div_ctl.link_ok && (div_ctl.link_sat || div_link.quo != '0);
        if (link_good) begin
            n_out_pct = link_pct;
        end else if (div_ctl.lvl_ok) begin
            n_out_pct = div_lvl.quo;
        end else begin
            n_out_pct = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pct <= n_out_pct;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.quality_percent = r_out_pct;

`ifndef ASSERT_OFF
    // Result never exceeds full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pct <= C_PCT_W'(C_FULL_PERCENT)))
        else $error("quality_percent above full scale");

    // An accepted report enters the prep stage on the next edge
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> pre_valid)
        else $error("accepted report lost at prep stage");

    // A held pipeline keeps the divider output in place
    a_hold_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && div_valid) |=> (div_valid && $stable(div_link) && $stable(div_lvl)))
        else $error("divider stage changed while stalled");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for signal_quality_percent: directed table, then random phases.
// Depends on sqp_pkg (types, constants, register indexes) and the channel interfaces in sqp_if.
`timescale 1ns / 1ps

module tb;
    import sqp_pkg::*;

    typedef struct packed {
        logic [C_BYTE_W-1:0] link_quality;
        logic [C_BYTE_W-1:0] signal_level;
        logic [C_BYTE_W-1:0] noise_level;
        logic                quality_invalid;
        logic                level_invalid;
        logic                noise_invalid;
    } t_report;

    typedef struct {
        t_cfg               cfg;
        t_report            rpt;
        bit                 typed;
        logic [C_PCT_W-1:0] pct;
    } t_row;

    localparam int RPT_W        = $bits(t_report);
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 12;
    localparam int STALL_CYCLES = 80;
    localparam int IDLE_PCT     = 14;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int CALM_PHASE   = 4;
    localparam int STALL_ITEM   = 40;
    localparam int MAX_REPORTS  = 10;

    // Indexes past the last register; writes there must be dropped
    localparam logic [C_IDX_W-1:0] REG_SPARE_FIRST = 3'd6;

    localparam bit TYPED   = 1'b1;
    localparam bit PREDICT = 1'b0;

    logic clk = 1'b0;
    logic rst_n;

    sqp_cfg_if cfg_if ();
    sqp_in_if  in_if ();
    sqp_out_if out_if ();

    signal_quality_percent DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_cfg               cfg_model;
    logic [C_PCT_W-1:0] expected_pct[$];
    t_row               dir_rows[$];
    int                 mismatch_cnt = 0;
    int                 cycle_cnt    = 0;
    bit                 calm         = 1'b0;
    bit                 stall_req    = 1'b0;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_cfg mk_cfg(logic [7:0] mq, logic [7:0] ml, logic [7:0] mn,
                                    bit qi, bit li, bit ni);
        t_cfg c;
        c.max_quality         = mq;
        c.level_scale         = ml;
        c.max_noise           = mn;
        c.max_quality_invalid = qi;
        c.level_scale_invalid = li;
        c.max_noise_invalid   = ni;
        return c;
    endfunction

    function automatic t_report mk_rpt(logic [7:0] lq, logic [7:0] sl, logic [7:0] nl,
                                       bit qi, bit li, bit ni);
        t_report r;
        r.link_quality    = lq;
        r.signal_level    = sl;
        r.noise_level     = nl;
        r.quality_invalid = qi;
        r.level_invalid   = li;
        r.noise_invalid   = ni;
        return r;
    endfunction

    function automatic void add_row(t_cfg c, t_report r, bit typed, logic [C_PCT_W-1:0] pct);
        t_row row;
        row.cfg   = c;
        row.rpt   = r;
        row.typed = typed;
        row.pct   = pct;
        dir_rows.push_back(row);
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Signal percent for one report under the given register set
    function automatic logic [C_PCT_W-1:0] calc_percent(t_cfg c, t_report r);
        int lq, sl, nl, mq, ml, mn;
        int pct, lvl_pct, lvl, noise, a, b;
        bit own_noise_ok, floor_ok;
        lq = r.link_quality;
        sl = r.signal_level;
        nl = r.noise_level;
        mq = c.max_quality;
        ml = c.level_scale;
        mn = c.max_noise;
        own_noise_ok = (nl > 0) && !r.noise_invalid;
        floor_ok     = (mn > 0) && !c.max_noise_invalid;
        pct     = -1;
        lvl_pct = -1;

        // link ratio first
        if (mq != 0 && !c.max_quality_invalid && !r.quality_invalid)
            pct = (C_FULL_PERCENT * lq) / mq;

        // level figure: dBm estimate or relative RSSI
        if (ml == 0 && !c.level_scale_invalid && !r.level_invalid &&
            (own_noise_ok || floor_ok)) begin
            lvl = clamp_int(sl - C_DBM_OFFSET, C_NOISE_FLOOR_DBM, C_SIGNAL_MAX_DBM);
            if (own_noise_ok)
                noise = nl - C_DBM_OFFSET;
            else if (floor_ok)
                noise = mn - C_DBM_OFFSET;
            else
                noise = C_NOISE_FLOOR_DBM;
            noise = clamp_int(noise, C_NOISE_FLOOR_DBM, C_SIGNAL_MAX_DBM);
            a = C_SIGNAL_MAX_DBM - lvl;
            b = C_SIGNAL_MAX_DBM - noise;
            // integer division truncates toward zero
            lvl_pct = (b == 0) ? 0 : (C_FULL_PERCENT * b - C_DBM_SPAN * a) / b;
        end else if (ml != 0 && !c.level_scale_invalid && !r.level_invalid) begin
            lvl_pct = (C_FULL_PERCENT * clamp_int(sl, 0, ml)) / ml;
        end

        if (pct < 1 && lvl_pct >= 0)
            pct = lvl_pct;
        return C_PCT_W'(clamp_int(pct, 0, C_FULL_PERCENT));
    endfunction

    // Mirror one register write into the shadow set
    function automatic void apply_reg(logic [C_IDX_W-1:0] idx, logic [C_BYTE_W-1:0] d);
        case (idx)
            REG_MAX_QUALITY:         cfg_model.max_quality         = d;
            REG_LEVEL_SCALE:         cfg_model.level_scale         = d;
            REG_MAX_NOISE:           cfg_model.max_noise           = d;
            REG_MAX_QUALITY_INVALID: cfg_model.max_quality_invalid = d[0];
            REG_LEVEL_SCALE_INVALID: cfg_model.level_scale_invalid = d[0];
            REG_MAX_NOISE_INVALID:   cfg_model.max_noise_invalid   = d[0];
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.max_quality         = pick_byte();
        c.level_scale         = ($urandom_range(0, 1) == 0) ? 8'h00 : pick_byte();
        c.max_noise           = pick_byte();
        c.max_quality_invalid = ($urandom_range(0, 3) == 0);
        c.level_scale_invalid = ($urandom_range(0, 3) == 0);
        c.max_noise_invalid   = ($urandom_range(0, 3) == 0);
        return c;
    endfunction

    // Mostly plausible reports for the current registers, the rest raw noise
    function automatic t_report make_report(t_cfg c);
        t_report r;
        int      top;
        r = t_report'(RPT_W'($urandom));
        if ($urandom_range(0, 99) < 75) begin
            r.quality_invalid = ($urandom_range(0, 9) == 0);
            r.level_invalid   = ($urandom_range(0, 9) == 0);
            r.noise_invalid   = ($urandom_range(0, 5) == 0);
            top = c.max_quality + c.max_quality / 4;
            if ($urandom_range(0, 3) == 0)
                r.link_quality = 8'($urandom_range(0, 2));
            else
                r.link_quality = 8'($urandom_range(0, top > 255 ? 255 : top));
            if (c.level_scale == 0) begin
                r.signal_level = 8'($urandom_range(150, 245));
            end else begin
                top = c.level_scale + 8;
                r.signal_level = 8'($urandom_range(0, top > 255 ? 255 : top));
            end
            r.noise_level = ($urandom_range(0, 4) == 0) ? 8'h00
                                                        : 8'($urandom_range(150, 245));
        end
        return r;
    endfunction

    // Write all six registers plus one spare index; leaves the channel idle
    task automatic load_config(input t_cfg c);
        logic [C_IDX_W-1:0]  idx;
        logic [C_BYTE_W-1:0] d;
        for (int i = 0; i <= 6; i++) begin
            if (i == 6)
                idx = REG_SPARE_FIRST + C_IDX_W'($urandom_range(0, 1));
            else
                idx = t_cfg_idx'(i);
            case (idx)
                REG_MAX_QUALITY:         d = c.max_quality;
                REG_LEVEL_SCALE:         d = c.level_scale;
                REG_MAX_NOISE:           d = c.max_noise;
                REG_MAX_QUALITY_INVALID: d = {7'($urandom), c.max_quality_invalid};
                REG_LEVEL_SCALE_INVALID: d = {7'($urandom), c.level_scale_invalid};
                REG_MAX_NOISE_INVALID:   d = {7'($urandom), c.max_noise_invalid};
                default:                 d = 8'($urandom);
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= d;
            @(posedge clk);
            while (!cfg_if.ready) @(posedge clk);
            apply_reg(idx, d);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Offer one report, with random idle cycles ahead of it; valid stays high after
    task automatic send_report(input t_report r, input bit typed,
                               input logic [C_PCT_W-1:0] pct);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid           <= 1'b1;
        in_if.link_quality    <= r.link_quality;
        in_if.signal_level    <= r.signal_level;
        in_if.noise_level     <= r.noise_level;
        in_if.quality_invalid <= r.quality_invalid;
        in_if.level_invalid   <= r.level_invalid;
        in_if.noise_invalid   <= r.noise_invalid;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        expected_pct.push_back(typed ? pct : calc_percent(cfg_model, r));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_pct.size() != 0) @(posedge clk);
    endtask

    task automatic log_error(input string msg);
        if (mismatch_cnt < MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // Directed table: typed values only where they are obvious
    function automatic void build_table();
        t_cfg c;
        c = mk_cfg(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1);
        add_row(c, mk_rpt(8'd200, 8'd200, 8'd200, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        c = mk_cfg(8'd100, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
        add_row(c, mk_rpt(8'd100, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd100);
        add_row(c, mk_rpt(8'd0, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        add_row(c, mk_rpt(8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd100);
        add_row(c, mk_rpt(8'd100, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0), TYPED, 7'd0);
        c = mk_cfg(8'd255, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
        add_row(c, mk_rpt(8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd100);
        add_row(c, mk_rpt(8'd1, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        c = mk_cfg(8'd255, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1);
        add_row(c, mk_rpt(8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        // dBm mode, own noise byte only
        c = mk_cfg(8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1);
        add_row(c, mk_rpt(8'd0, 8'd236, 8'd166, 1'b1, 1'b0, 1'b0), TYPED, 7'd100);
        add_row(c, mk_rpt(8'd0, 8'd166, 8'd166, 1'b0, 1'b0, 1'b0), TYPED, 7'd30);
        // noise clamps to the top: zero span
        add_row(c, mk_rpt(8'd0, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        // no usable noise anywhere
        add_row(c, mk_rpt(8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        // negative level figure counts as absent
        add_row(c, mk_rpt(8'd0, 8'd166, 8'd226, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        add_row(c, mk_rpt(8'd0, 8'd236, 8'd166, 1'b0, 1'b0, 1'b1), TYPED, 7'd0);
        add_row(c, mk_rpt(8'd0, 8'd236, 8'd166, 1'b0, 1'b1, 1'b0), TYPED, 7'd0);
        // dBm mode falling back to the card noise floor
        c = mk_cfg(8'd0, 8'd0, 8'd176, 1'b1, 1'b0, 1'b0);
        add_row(c, mk_rpt(8'd0, 8'd236, 8'd0, 1'b0, 1'b0, 1'b1), TYPED, 7'd100);
        add_row(c, mk_rpt(8'd0, 8'd200, 8'd99, 1'b0, 1'b0, 1'b1), PREDICT, 7'd0);
        add_row(c, mk_rpt(8'd0, 8'd230, 8'd231, 1'b0, 1'b0, 1'b0), PREDICT, 7'd0);
        // link ratio of zero hands over to the level figure, a ratio of one does not
        c = mk_cfg(8'd200, 8'd0, 8'd166, 1'b0, 1'b0, 1'b0);
        add_row(c, mk_rpt(8'd1, 8'd200, 8'd0, 1'b0, 1'b0, 1'b0), PREDICT, 7'd0);
        add_row(c, mk_rpt(8'd2, 8'd200, 8'd0, 1'b0, 1'b0, 1'b0), PREDICT, 7'd0);
        // relative RSSI
        c = mk_cfg(8'd0, 8'd60, 8'd0, 1'b1, 1'b0, 1'b1);
        add_row(c, mk_rpt(8'd0, 8'd30, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd50);
        add_row(c, mk_rpt(8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd100);
        add_row(c, mk_rpt(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd0);
        add_row(c, mk_rpt(8'd0, 8'd30, 8'd0, 1'b0, 1'b1, 1'b0), TYPED, 7'd0);
        c = mk_cfg(8'd0, 8'd255, 8'd0, 1'b1, 1'b0, 1'b1);
        add_row(c, mk_rpt(8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0), TYPED, 7'd100);
        add_row(c, mk_rpt(8'd0, 8'd128, 8'd0, 1'b0, 1'b0, 1'b0), PREDICT, 7'd0);
    endfunction

    // Result receiver: random back-pressure, plus long holds on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_req) begin
                stall_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk) begin
        logic [C_PCT_W-1:0] want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_pct.size() == 0) begin
                log_error($sformatf("result %0d with nothing expected",
                                    out_if.quality_percent));
            end else begin
                want = expected_pct.pop_front();
                if (out_if.quality_percent !== want)
                    log_error($sformatf("quality_percent expected %0d got %0d",
                                        want, out_if.quality_percent));
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial begin
        t_cfg    phase_cfg;
        t_report r;
        rst_n                 <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= '0;
        cfg_if.data           <= '0;
        in_if.valid           <= 1'b0;
        in_if.link_quality    <= '0;
        in_if.signal_level    <= '0;
        in_if.noise_level     <= '0;
        in_if.quality_invalid <= 1'b0;
        in_if.level_invalid   <= 1'b0;
        in_if.noise_invalid   <= 1'b0;
        cfg_model = mk_cfg(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1);
        build_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows, reprogramming whenever the row asks for other registers
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg != cfg_model) begin
                drain();
                load_config(dir_rows[i].cfg);
            end
            send_report(dir_rows[i].rpt, dir_rows[i].typed, dir_rows[i].pct);
        end

        // random phases, each under its own register set
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0:       phase_cfg = mk_cfg(8'd100, 8'd0, 8'd176, 1'b0, 1'b0, 1'b0);
                1:       phase_cfg = mk_cfg(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
                2:       phase_cfg = mk_cfg(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
                default: phase_cfg = rand_cfg();
            endcase
            load_config(phase_cfg);
            calm = (p == CALM_PHASE);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold the receiver off so the pipeline fills and stalls its input
                if ((p == 2 || p == 5) && k == STALL_ITEM)
                    stall_req = 1'b1;
                r = make_report(cfg_model);
                send_report(r, PREDICT, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && expected_pct.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
